/* hdl/atfg_pkg.sv */
// Shared constants and arithmetic helpers for the arc triangle fan generator.
// No dependencies; used by arc_triangle_fan_generator_unit and the testbench.
package atfg_pkg;

    localparam int MAX_SIDES    = 62;
    localparam int INDEX_BITS   = 16;
    localparam int COORD_BITS   = 24;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_HALF    = 2'd1;
    localparam logic [1:0] MODE_QUARTER = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;

    // Arctangent of 2^-i in Q2.30 turn-scaled units.
    function automatic logic signed [31:0] cordic_atan(input logic [3:0] i);
        logic signed [31:0] a;
        case (i)
            4'd0:    a = 32'sd536870912;
            4'd1:    a = 32'sd316933406;
            4'd2:    a = 32'sd167458907;
            4'd3:    a = 32'sd85004756;
            4'd4:    a = 32'sd42667331;
            4'd5:    a = 32'sd21354465;
            4'd6:    a = 32'sd10679838;
            4'd7:    a = 32'sd5340245;
            4'd8:    a = 32'sd2670163;
            4'd9:    a = 32'sd1335087;
            4'd10:   a = 32'sd667544;
            4'd11:   a = 32'sd333772;
            4'd12:   a = 32'sd166886;
            4'd13:   a = 32'sd83443;
            4'd14:   a = 32'sd41722;
            default: a = 32'sd20861;
        endcase
        return a;
    endfunction

    // Rounds a Q2.30 CORDIC output to Q1.14 and clamps it to one.
    function automatic logic signed [15:0] round_q14(input logic signed [31:0] v);
        logic signed [32:0] s;
        logic signed [16:0] r;
        s = 33'(v) + 33'sd32768;
        r = 17'(s >>> 16);
        if (r > 17'sd16384)
            return 16'sd16384;
        else if (r < -17'sd16384)
            return -16'sd16384;
        return 16'(r);
    endfunction

    // Centre plus rounded offset, saturated to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] place(
        input logic signed [COORD_BITS-1:0] center,
        input logic signed [39:0]           prod
    );
        logic signed [40:0] rnd;
        logic signed [41:0] sum;
        rnd = 41'(prod) + 41'sd8192;
        sum = 42'(center) + 42'(rnd >>> 14);
        if (sum > 42'sd8388607)
            return 24'sh7FFFFF;
        else if (sum < -42'sd8388608)
            return 24'sh800000;
        return 24'(sum);
    endfunction

endpackage

/* hdl/arc_triangle_fan_generator_unit.sv */
// Arc triangle fan generator: one arc descriptor in, a triangle fan out.
// For each arc: a setup pass (the step divider, then the centre beat), then for each
// perimeter vertex: 16 CORDIC iterations, rounding, two multiplies, emit;
// plus a full circle's closing triangle. One arc at a time; a new arc is taken
// once the previous one is issued. The unused mode gives one empty last beat.
// Reset (rst_n, asynchronous) clears the sequencer, output valid and vertex
// counter.
module arc_triangle_fan_generator_unit
    import atfg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [22:0]           radius,
    input  logic [7:0]            side_count,
    input  logic [15:0]           rotation,
    input  logic signed [23:0]    center_x,
    input  logic signed [23:0]    center_y,
    input  logic [31:0]           color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  has_vertex,
    output logic [15:0]           vertex_index,
    output logic signed [23:0]    pos_x,
    output logic signed [23:0]    pos_y,
    output logic [31:0]           vertex_color,
    output logic                  has_triangle,
    output logic [15:0]           tri_a,
    output logic [15:0]           tri_b,
    output logic [15:0]           tri_c,
    output logic                  last
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CENTER, S_START, S_CORDIC, S_ROUND,
        S_MULX, S_MULY, S_VERT, S_CLOSE, S_NULL
    } state_t;

    state_t                state_reg;
    logic [15:0]           next_vertex_reg, base_reg;
    logic [1:0]            mode_reg;
    logic [22:0]           radius_reg;
    logic [15:0]           rot_reg;
    logic signed [23:0]    cx_reg, cy_reg;
    logic [31:0]           color_reg;
    logic [5:0]            n_reg;
    logic [6:0]            count_reg, i_reg;
    logic [4:0]            div_cnt_reg;
    logic [6:0]            rem_reg;
    logic [16:0]           qd_reg, frac_reg;
    logic [5:0]            rd_reg, r_reg;
    logic [1:0]            quad_reg;
    logic signed [31:0]    x_reg, y_reg, z_reg;
    logic [3:0]            step_reg;
    logic signed [15:0]    tc_reg, ts_reg;
    logic signed [39:0]    prod_reg;
    logic signed [23:0]    px_reg;

    logic                  ov_reg, hv_reg, ht_reg, last_reg;
    logic [15:0]           vi_reg, ta_reg, tb_reg, tc_idx_reg;
    logic signed [23:0]    ox_reg, oy_reg;
    logic [31:0]           ocol_reg;

    logic                  slot_free;
    logic                  emit_beat;
    logic [5:0]            n_clamp;
    logic [16:0]           dividend;
    logic [7:0]            rem_shift;
    logic [6:0]            r_sum;
    logic [15:0]           ang;
    logic signed [15:0]    cc, ss, mul_a;
    logic signed [39:0]    prod;
    logic [15:0]           k_idx;

    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign emit_beat = slot_free && (state_reg inside {S_CENTER, S_VERT, S_CLOSE, S_NULL});

    always_comb
    begin
        if (side_count > 8'(MAX_SIDES))
            n_clamp = 6'(MAX_SIDES);
        else if (mode == MODE_QUARTER && side_count == 8'd0)
            n_clamp = 6'd1;
        else if (mode != MODE_QUARTER && side_count < 8'd3)
            n_clamp = 6'd3;
        else
            n_clamp = side_count[5:0];
    end

    // Arc span 2^(16-mode) angle units (1/65536 turn), divided by n once per arc into quotient and remainder.
    assign dividend  = 17'h10000 >> mode_reg;
    assign rem_shift = {rem_reg, dividend[div_cnt_reg]};
    assign r_sum     = {1'b0, r_reg} + {1'b0, rd_reg};

    assign ang = frac_reg[15:0] + ((mode_reg == MODE_FULL) ? 16'd0 : rot_reg);

    always_comb
    begin
        cc = round_q14(x_reg);
        ss = round_q14(y_reg);
    end

    assign mul_a = (state_reg == S_MULX) ? tc_reg : ts_reg;
    assign prod  = 40'(mul_a) * 40'($signed({17'd0, radius_reg}));
    assign k_idx = base_reg + 16'(i_reg) + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            next_vertex_reg <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && !emit_beat)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg    <= mode;
                        radius_reg  <= radius;
                        rot_reg     <= rotation;
                        cx_reg      <= center_x;
                        cy_reg      <= center_y;
                        color_reg   <= color;
                        n_reg       <= n_clamp;
                        base_reg    <= next_vertex_reg;
                        div_cnt_reg <= 5'd16;
                        rem_reg     <= '0;
                        qd_reg      <= '0;
                        if (mode == MODE_UNUSED)
                            state_reg <= S_NULL;
                        else
                        begin
                            count_reg <= (mode == MODE_FULL) ? 7'(n_clamp)
                                                             : 7'(n_clamp) + 7'd1;
                            next_vertex_reg <= next_vertex_reg + 16'(n_clamp)
                                + ((mode == MODE_FULL) ? 16'd1 : 16'd2);
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (rem_shift >= {2'b0, n_reg})
                    begin
                        rem_reg <= 7'(rem_shift - {2'b0, n_reg});
                        qd_reg  <= {qd_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[6:0];
                        qd_reg  <= {qd_reg[15:0], 1'b0};
                    end
                    if (div_cnt_reg == 5'd0)
                        state_reg <= S_CENTER;
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                S_CENTER:
                begin
                    rd_reg   <= rem_reg[5:0];
                    frac_reg <= '0;
                    r_reg    <= '0;
                    i_reg    <= '0;
                    if (slot_free)
                    begin
                        ov_reg     <= 1'b1;
                        hv_reg     <= 1'b1;
                        vi_reg     <= base_reg;
                        ox_reg     <= cx_reg;
                        oy_reg     <= cy_reg;
                        ocol_reg   <= color_reg;
                        ht_reg     <= 1'b0;
                        ta_reg     <= '0;
                        tb_reg     <= '0;
                        tc_idx_reg <= '0;
                        last_reg   <= 1'b0;
                        state_reg  <= S_START;
                    end
                end
                S_START:
                begin
                    quad_reg  <= ang[15:14];
                    x_reg     <= CORDIC_GAIN_INV;
                    y_reg     <= '0;
                    z_reg     <= $signed({2'b00, ang[13:0], 16'd0});
                    step_reg  <= '0;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (!z_reg[31])
                    begin
                        x_reg <= x_reg - (y_reg >>> step_reg);
                        y_reg <= y_reg + (x_reg >>> step_reg);
                        z_reg <= z_reg - cordic_atan(step_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg + (y_reg >>> step_reg);
                        y_reg <= y_reg - (x_reg >>> step_reg);
                        z_reg <= z_reg + cordic_atan(step_reg);
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(CORDIC_STEPS - 1))
                        state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    case (quad_reg)
                        2'd0:    begin tc_reg <= cc;  ts_reg <= ss;  end
                        2'd1:    begin tc_reg <= -ss; ts_reg <= cc;  end
                        2'd2:    begin tc_reg <= -cc; ts_reg <= -ss; end
                        default: begin tc_reg <= ss;  ts_reg <= -cc; end
                    endcase
                    state_reg <= S_MULX;
                end
                S_MULX:
                begin
                    prod_reg  <= prod;
                    state_reg <= S_MULY;
                end
                S_MULY:
                begin
                    px_reg    <= place(cx_reg, prod_reg);
                    prod_reg  <= prod;
                    state_reg <= S_VERT;
                end
                S_VERT:
                begin
                    if (slot_free)
                    begin
                        ov_reg     <= 1'b1;
                        hv_reg     <= 1'b1;
                        vi_reg     <= k_idx;
                        ox_reg     <= px_reg;
                        oy_reg     <= place(cy_reg, prod_reg);
                        ocol_reg   <= color_reg;
                        ht_reg     <= (i_reg != 7'd0);
                        ta_reg     <= (i_reg != 7'd0) ? base_reg : 16'd0;
                        tb_reg     <= (i_reg != 7'd0) ? k_idx - 16'd1 : 16'd0;
                        tc_idx_reg <= (i_reg != 7'd0) ? k_idx : 16'd0;
                        last_reg   <= (mode_reg != MODE_FULL) &&
                                      (i_reg + 7'd1 == count_reg);
                        // Next angle: add the step quotient, carry the remainder.
                        if (r_sum >= {1'b0, n_reg})
                        begin
                            r_reg    <= 6'(r_sum - {1'b0, n_reg});
                            frac_reg <= frac_reg + qd_reg + 17'd1;
                        end
                        else
                        begin
                            r_reg    <= r_sum[5:0];
                            frac_reg <= frac_reg + qd_reg;
                        end
                        i_reg <= i_reg + 7'd1;
                        if (i_reg + 7'd1 == count_reg)
                            state_reg <= (mode_reg == MODE_FULL) ? S_CLOSE : S_IDLE;
                        else
                            state_reg <= S_START;
                    end
                end
                S_CLOSE:
                begin
                    if (slot_free)
                    begin
                        ov_reg     <= 1'b1;
                        hv_reg     <= 1'b0;
                        vi_reg     <= '0;
                        ox_reg     <= '0;
                        oy_reg     <= '0;
                        ocol_reg   <= '0;
                        ht_reg     <= 1'b1;
                        ta_reg     <= base_reg;
                        tb_reg     <= base_reg + 16'(n_reg);
                        tc_idx_reg <= base_reg + 16'd1;
                        last_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_NULL:
                begin
                    if (slot_free)
                    begin
                        ov_reg     <= 1'b1;
                        hv_reg     <= 1'b0;
                        vi_reg     <= '0;
                        ox_reg     <= '0;
                        oy_reg     <= '0;
                        ocol_reg   <= '0;
                        ht_reg     <= 1'b0;
                        ta_reg     <= '0;
                        tb_reg     <= '0;
                        tc_idx_reg <= '0;
                        last_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = ov_reg;
    assign has_vertex   = hv_reg;
    assign vertex_index = vi_reg;
    assign pos_x        = ox_reg;
    assign pos_y        = oy_reg;
    assign vertex_color = ocol_reg;
    assign has_triangle = ht_reg;
    assign tri_a        = ta_reg;
    assign tri_b        = tb_reg;
    assign tri_c        = tc_idx_reg;
    assign last         = last_reg;

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sequencer stayed idle after taking an arc");

    a_no_vertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_vertex |-> vertex_index == 16'd0 && pos_x == 24'sd0)
        else $error("beat without a vertex carries vertex data");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CORDIC |-> r_reg < n_reg && rd_reg < n_reg)
        else $error("angle remainder out of range");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for arc_triangle_fan_generator_unit: directed table, then random arcs.
// Predicts each fan with its own CORDIC model; depends on atfg_pkg and the unit's RTL.
module testbench;
    import atfg_pkg::*;

    typedef struct packed {
        logic        hv;
        logic [15:0] vi;
        logic [23:0] px;
        logic [23:0] py;
        logic [31:0] col;
        logic        ht;
        logic [15:0] ta;
        logic [15:0] tb;
        logic [15:0] tc;
        logic        lst;
    } fan_beat_t;

    typedef struct {
        logic [1:0]  md;
        logic [22:0] rad;
        logic [7:0]  sides;
        logic [15:0] rot;
        logic [23:0] cx;
        logic [23:0] cy;
        logic [31:0] col;
        logic        typed;   // row carries a typed-in first beat
        fan_beat_t   first;
    } arc_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic [22:0] radius = '0;
    logic [7:0] side_count = '0;
    logic [15:0] rotation = '0;
    logic signed [23:0] center_x = '0;
    logic signed [23:0] center_y = '0;
    logic [31:0] color = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic has_vertex, has_triangle, last;
    logic [15:0] vertex_index, tri_a, tri_b, tri_c;
    logic signed [23:0] pos_x, pos_y;
    logic [31:0] vertex_color;

    fan_beat_t pending_beats[$];
    logic [15:0] vertex_counter = '0;
    int errors = 0;
    bit stim_done = 0;
    bit hold_off = 0;

    arc_triangle_fan_generator_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(logic [31:0] ang, output longint c, output longint s);
        longint x, y, z, dx, dy, cc, ss;
        x = CORDIC_GAIN_INV;
        y = 0;
        z = longint'(ang & 32'h3FFF_FFFF);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(cordic_atan(i[3:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(cordic_atan(i[3:0]));
            end
        end
        cc = floor_shift(x + 32768, 16);
        ss = floor_shift(y + 32768, 16);
        if (cc > 16384) cc = 16384;
        if (cc < -16384) cc = -16384;
        if (ss > 16384) ss = 16384;
        if (ss < -16384) ss = -16384;
        case (ang[31:30])
            2'd0: begin c = cc;  s = ss;  end
            2'd1: begin c = -ss; s = cc;  end
            2'd2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
        endcase
    endfunction

    function automatic logic [23:0] offset_point(logic [23:0] ctr, longint t, longint rad);
        longint v;
        v = longint'($signed(ctr)) + floor_shift(t * rad + 8192, 14);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    // Appends the expected fan for one arc and, unless the mode is unused, moves the vertex counter on.
    task automatic predict_fan(arc_row_t a);
        int n, cnt, sh;
        longint c, s, frac;
        logic [31:0] ang, rot32;
        logic [15:0] base, k;
        fan_beat_t b;
        if (a.md == MODE_UNUSED)
        begin
            b = '0;
            b.lst = 1'b1;
            pending_beats.push_back(b);
            return;
        end
        n = a.sides;
        if (n > MAX_SIDES) n = MAX_SIDES;
        if (n < ((a.md == MODE_QUARTER) ? 1 : 3)) n = (a.md == MODE_QUARTER) ? 1 : 3;
        cnt = (a.md == MODE_FULL) ? n : n + 1;
        sh = a.md;
        rot32 = (a.md == MODE_FULL) ? 32'd0 : {a.rot, 16'd0};
        base = vertex_counter;
        b = '0;
        b.hv = 1'b1; b.vi = base; b.px = a.cx; b.py = a.cy; b.col = a.col;
        pending_beats.push_back(b);
        for (int i = 0; i < cnt; i++)
        begin
            frac = (longint'(i) << (ANGLE_BITS - sh)) / n;
            ang = {frac[15:0], 16'd0} + rot32;
            sin_cos(ang, c, s);
            k = base + 16'(i + 1);
            b = '0;
            b.hv = 1'b1; b.vi = k; b.col = a.col;
            b.px = offset_point(a.cx, c, a.rad);
            b.py = offset_point(a.cy, s, a.rad);
            if (i >= 1)
            begin
                b.ht = 1'b1; b.ta = base; b.tb = k - 16'd1; b.tc = k;
            end
            b.lst = (a.md != MODE_FULL) && (i + 1 == cnt);
            pending_beats.push_back(b);
        end
        if (a.md == MODE_FULL)
        begin
            b = '0;
            b.ht = 1'b1; b.ta = base; b.tb = base + 16'(n); b.tc = base + 16'd1;
            b.lst = 1'b1;
            pending_beats.push_back(b);
        end
        vertex_counter = base + 16'(cnt + 1);
    endtask

    // Valid stays high from one arc to the next unless a gap is drawn.
    task automatic send_arc(arc_row_t a);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode <= a.md; radius <= a.rad; side_count <= a.sides; rotation <= a.rot;
        center_x <= a.cx; center_y <= a.cy; color <= a.col;
        in_valid <= 1'b1;
        predict_fan(a);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic arc_row_t random_arc();
        arc_row_t a;
        a.md = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        a.rad = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 1 << 20));
        a.sides = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        a.rot = 16'($urandom);
        a.cx = 24'($urandom);
        a.cy = 24'($urandom);
        a.col = $urandom;
        a.typed = 1'b0;
        a.first = '0;
        return a;
    endfunction

    function automatic arc_row_t row(logic [1:0] md, logic [22:0] rad, logic [7:0] sd,
                                     logic [15:0] rt, logic [23:0] x, logic [23:0] y,
                                     logic [31:0] cl);
        arc_row_t a;
        a.md = md; a.rad = rad; a.sides = sd; a.rot = rt;
        a.cx = x; a.cy = y; a.col = cl; a.typed = 1'b0; a.first = '0;
        return a;
    endfunction

    // Stimulus.
    initial
    begin
        arc_row_t dir[$];
        arc_row_t a;
        fan_beat_t zero_beat;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        zero_beat = '0;
        zero_beat.lst = 1'b1;
        dir.push_back(row(MODE_FULL, 23'd4096, 8'd0, 16'd0, 24'd0, 24'd0, 32'h0));
        dir.push_back(row(MODE_HALF, 23'd4096, 8'd1, 16'hFFFF, 24'd0, 24'd0, 32'hFFFF_FFFF));
        dir.push_back(row(MODE_QUARTER, 23'd4096, 8'd0, 16'h4000, 24'd0, 24'd0, 32'h1234_5678));
        dir.push_back(row(MODE_QUARTER, 23'd100, 8'd1, 16'h8000, 24'd5, 24'd7, 32'hA5A5_5A5A));
        dir.push_back(row(MODE_FULL, 23'd0, 8'd8, 16'h1234, 24'h123456, 24'hEDCBA9, 32'h5A5A_A5A5));
        dir.push_back(row(MODE_FULL, 23'h7FFFFF, 8'd255, 16'h0, 24'h7FFFFF, 24'h800000, 32'h1));
        dir.push_back(row(MODE_HALF, 23'h7FFFFF, 8'd62, 16'hC000, 24'h800000, 24'h7FFFFF, 32'h2));
        dir.push_back(row(MODE_QUARTER, 23'h7FFFFF, 8'd63, 16'h2000, 24'h7FF000, 24'h800FFF, 32'h3));
        dir.push_back(row(MODE_HALF, 23'd40000, 8'd3, 16'h0001, 24'h000100, 24'hFFFF00, 32'h4));
        dir.push_back(row(MODE_FULL, 23'd12345, 8'd61, 16'h5555, 24'hABCDEF, 24'h012345, 32'h5));
        a = row(MODE_UNUSED, 23'h7FFFFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        a.typed = 1'b1; a.first = zero_beat;
        dir.push_back(a);
        foreach (dir[i])
        begin
            if (dir[i].typed)
            begin
                mode <= dir[i].md; radius <= dir[i].rad; side_count <= dir[i].sides;
                rotation <= dir[i].rot; center_x <= dir[i].cx; center_y <= dir[i].cy;
                color <= dir[i].col;
                in_valid <= 1'b1;
                pending_beats.push_back(dir[i].first);
                @(posedge clk);
                while (!in_ready) @(posedge clk);
            end
            else
                send_arc(dir[i]);
        end
        for (int i = 0; i < 170; i++)
            send_arc(random_arc());
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Long receiver hold-off early in the run, so the unit backs up.
    initial
    begin
        wait (rst_n);
        repeat (100) @(posedge clk);
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 49) == 0)
            out_ready <= 1'b0;
        else if (!out_ready)
            out_ready <= ($urandom_range(0, 3) == 0);
        else
            out_ready <= ($urandom_range(0, 5) != 0);
    end

    // Compare each beat with the oldest expectation.
    always @(posedge clk)
    begin
        fan_beat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: vertex_index %0d", vertex_index);
                errors++;
            end
            else
            begin
                e = pending_beats.pop_front();
                if (has_vertex !== e.hv)
                    begin $error("has_vertex exp %0h got %0h", e.hv, has_vertex); errors++; end
                if (vertex_index !== e.vi)
                    begin $error("vertex_index exp %0h got %0h", e.vi, vertex_index); errors++; end
                if (pos_x !== e.px)
                    begin $error("pos_x exp %0h got %0h", e.px, pos_x); errors++; end
                if (pos_y !== e.py)
                    begin $error("pos_y exp %0h got %0h", e.py, pos_y); errors++; end
                if (vertex_color !== e.col)
                    begin $error("vertex_color exp %0h got %0h", e.col, vertex_color); errors++; end
                if (has_triangle !== e.ht)
                    begin $error("has_triangle exp %0h got %0h", e.ht, has_triangle); errors++; end
                if (tri_a !== e.ta)
                    begin $error("tri_a exp %0h got %0h", e.ta, tri_a); errors++; end
                if (tri_b !== e.tb)
                    begin $error("tri_b exp %0h got %0h", e.tb, tri_b); errors++; end
                if (tri_c !== e.tc)
                    begin $error("tri_c exp %0h got %0h", e.tc, tri_c); errors++; end
                if (last !== e.lst)
                    begin $error("last exp %0h got %0h", e.lst, last); errors++; end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (1500) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
